// File: sv/scba_pkg.sv
// Shared types and constants for the size-class bitmap allocator.
`default_nettype none

package scba_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W      = 32;
  localparam int HDR_W      = 12;
  localparam int STATUS_W   = 2;
  localparam int PAGE_W     = 4;
  localparam int SLOT_W     = 6;
  localparam int BLK_W      = 11;
  localparam int BIG_W      = 33;

  // Page table geometry; the page index port holds 16 entries
  localparam int PAGES      = 16;
  localparam int PAGE_BYTES = 4096;

  // Page table entry layout: class code above a 64-bit used map
  localparam int MAP_W      = 64;
  localparam int CLASS_W    = 3;
  localparam int ENTRY_W    = CLASS_W + MAP_W;
  localparam int SLOT_CNT_W = 7;

  // Smallest class is 64 bytes, largest small request is 1024 bytes
  localparam int MIN_CLASS_LOG = 6;
  localparam int MAX_CLASS     = 4;
  localparam logic [REQ_W-1:0] SMALL_LIMIT = 32'd1024;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_ZERO  = 2'd0;
  localparam status_t ST_GRANT = 2'd1;
  localparam status_t ST_BIG   = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // Which result the datapath loads into its result register
  typedef enum logic [2:0] {
    RES_NONE,
    RES_ZERO,
    RES_FULL,
    RES_BIG,
    RES_GRANT
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     scan_init;
    logic     scan_issue;
    logic     take;
    logic     open_page;
    res_sel_t res_sel;
    logic     load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_zero;
    logic req_big;
    logic none_open;
    logic hit;
    logic scan_done;
    logic table_full;
    logic no_slots;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/scba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/scba_ctrl.sv
// Sequencing state machine for the size-class bitmap allocator.
`default_nettype none

module scba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire scba_pkg::dp_stat_t stat,
  output scba_pkg::dp_cmd_t       cmd
);

  import scba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_OPEN,
    S_PICK,
    S_BIG,
    S_EMIT
  } state_t;

  state_t state, state_next;

  // Input side takes a word only between requests
  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat.req_zero) begin
          cmd.res_sel = RES_ZERO;
          state_next  = S_EMIT;
        end else if (stat.req_big) begin
          state_next = S_BIG;
        end else if (stat.none_open) begin
          state_next = S_OPEN;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.take   = 1'b1;
          state_next = S_PICK;
        end else if (stat.scan_done) begin
          state_next = S_OPEN;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_OPEN: begin
        if (stat.table_full || stat.no_slots) begin
          cmd.res_sel = RES_FULL;
          state_next  = S_EMIT;
        end else begin
          cmd.open_page = 1'b1;
          state_next    = S_PICK;
        end
      end
      S_PICK: begin
        cmd.res_sel = RES_GRANT;
        state_next  = S_EMIT;
      end
      S_BIG: begin
        cmd.res_sel = RES_BIG;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/scba_dp.sv
// Datapath: request decode, page table scan, slot pick, page rounding, output register.
`default_nettype none

module scba_dp #(
  parameter int SLOTS_MAX  = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire scba_pkg::dp_cmd_t               cmd,
  output scba_pkg::dp_stat_t                   stat,
  input  wire logic                            cfg_we,
  input  wire logic [scba_pkg::HDR_W-1:0]      cfg_header,
  input  wire logic [scba_pkg::REQ_W-1:0]      req_in,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output scba_pkg::status_t                    out_status,
  output logic      [scba_pkg::PAGE_W-1:0]     out_page,
  output logic      [scba_pkg::SLOT_W-1:0]     out_slot,
  output logic      [scba_pkg::BLK_W-1:0]      out_block,
  output logic      [scba_pkg::BIG_W-1:0]      out_big
);

  import scba_pkg::*;

  localparam int IDXW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CNTW = $clog2(PAGES + 1);
  localparam int AVW  = $clog2(PAGE_BYTES + 1);
  localparam logic [CNTW-1:0]  PAGES_C  = CNTW'(PAGES);
  localparam logic [AVW-1:0]   PB_C     = AVW'(PAGE_BYTES);
  localparam logic [AVW-1:0]   SMAX_C   = AVW'(SLOTS_MAX);
  // Page size is a power of two, so rounding up is an add and a mask
  localparam logic [BIG_W-1:0] PAGE_MASK = BIG_W'(PAGE_BYTES - 1);

  // Configuration and table bookkeeping
  logic [HDR_W-1:0] header;
  logic [CNTW-1:0]  pages_open;

  // Captured request and its class
  logic [REQ_W-1:0]   req;
  logic [CLASS_W-1:0] code;

  // Scan pipeline
  logic [IDXW-1:0] ptr;
  logic [IDXW-1:0] pend_addr;
  logic            pend;
  logic            done_issue;

  // Chosen entry
  logic [IDXW-1:0]  found;
  logic [MAP_W-1:0] map_r;

  // Result held until the output register frees up
  status_t          res_status;
  logic [PAGE_W-1:0] res_page;
  logic [SLOT_W-1:0] res_slot;
  logic [BLK_W-1:0]  res_block;
  logic [BIG_W-1:0]  res_big;

  // RAM signals
  logic             ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CLASS_W-1:0] rd_class;
  logic [MAP_W-1:0]   rd_map;

  // New page geometry
  logic [AVW-1:0]        avail;
  logic [3:0]            shamt;
  logic [AVW-1:0]        slots_raw;
  logic [SLOT_CNT_W-1:0] slots;
  logic [MAP_W-1:0]      new_map;

  // Lowest free slot of the chosen page
  logic [SLOT_W-1:0] slot;
  logic [MAP_W-1:0]  slot_bit;

  scba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (found),
    .wr_data (ram_wdata),
    .rd_en   (cmd.scan_issue),
    .rd_addr (ptr),
    .rd_data (ram_rdata)
  );

  assign rd_class = ram_rdata[ENTRY_W-1:MAP_W];
  assign rd_map   = ram_rdata[MAP_W-1:0];

  // Size class: smallest power of two from 64 up that holds the request
  always_comb begin
    priority if (req <= 32'd64) begin
      code = 3'd0;
    end else if (req <= 32'd128) begin
      code = 3'd1;
    end else if (req <= 32'd256) begin
      code = 3'd2;
    end else if (req <= 32'd512) begin
      code = 3'd3;
    end else begin
      code = CLASS_W'(MAX_CLASS);
    end
  end

  // Slot count of a fresh page; the 12-bit header is always below the page size
  always_comb begin
    avail     = PB_C - AVW'(header);
    shamt     = 4'(code) + 4'(MIN_CLASS_LOG);
    slots_raw = avail >> shamt;
    if (slots_raw > SMAX_C) begin
      slots = SLOT_CNT_W'(SLOTS_MAX);
    end else begin
      slots = SLOT_CNT_W'(slots_raw);
    end
    for (int i = 0; i < MAP_W; i++) begin
      new_map[i] = (SLOT_CNT_W'(i) >= slots);
    end
  end

  // Lowest clear bit of the chosen map
  always_comb begin
    slot = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!map_r[i]) begin
        slot = SLOT_W'(i);
      end
    end
    slot_bit = MAP_W'(1) << slot;
  end

  assign ram_we    = (cmd.res_sel == RES_GRANT);
  assign ram_wdata = {code, map_r | slot_bit};

  // Status back to the controller
  always_comb begin
    stat.req_zero   = (req == '0);
    stat.req_big    = (req > SMALL_LIMIT);
    stat.none_open  = (pages_open == '0);
    stat.hit        = pend && (rd_class == code) && (rd_map != '1);
    stat.scan_done  = done_issue;
    stat.table_full = (pages_open == PAGES_C);
    stat.no_slots   = (slots == '0);
    stat.out_free   = !out_valid || !out_stall;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header     <= HDR_W'(32);
      pages_open <= '0;
      pend       <= 1'b0;
      done_issue <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        header <= cfg_header;
      end
      if (cmd.open_page) begin
        pages_open <= pages_open + CNTW'(1);
      end
      pend <= cmd.scan_issue;
      if (cmd.scan_init) begin
        done_issue <= 1'b0;
      end else if (cmd.scan_issue && (ptr == '0)) begin
        done_issue <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= req_in;
    end

    // Scan walks from the newest entry down to entry zero
    if (cmd.scan_init) begin
      ptr <= IDXW'(pages_open - CNTW'(1));
    end else if (cmd.scan_issue && (ptr != '0)) begin
      ptr <= ptr - IDXW'(1);
    end
    if (cmd.scan_issue) begin
      pend_addr <= ptr;
    end

    if (cmd.take) begin
      found <= pend_addr;
      map_r <= rd_map;
    end else if (cmd.open_page) begin
      found <= IDXW'(pages_open);
      map_r <= new_map;
    end

    // Result register
    unique case (cmd.res_sel)
      RES_ZERO, RES_FULL: begin
        res_status <= (cmd.res_sel == RES_ZERO) ? ST_ZERO : ST_FULL;
        res_page   <= '0;
        res_slot   <= '0;
        res_block  <= '0;
        res_big    <= '0;
      end
      RES_BIG: begin
        res_status <= ST_BIG;
        res_page   <= '0;
        res_slot   <= '0;
        res_block  <= '0;
        res_big    <= (BIG_W'(req) + PAGE_MASK) & ~PAGE_MASK;
      end
      RES_GRANT: begin
        res_status <= ST_GRANT;
        res_page   <= PAGE_W'(found);
        res_slot   <= slot;
        res_block  <= BLK_W'(64) << code;
        res_big    <= '0;
      end
      default: begin
      end
    endcase

    // Output word
    if (cmd.load_out) begin
      out_status <= res_status;
      out_page   <= res_page;
      out_slot   <= res_slot;
      out_block  <= res_block;
      out_big    <= res_big;
    end
  end

endmodule

`default_nettype wire

// File: sv/size_class_bitmap_allocator.sv
// Size-class bitmap slab allocator: top level joining controller, datapath and page table.
//
// Each input word is one allocation request (request_bytes). Each request gives
// exactly one output word: status, page_index, slot_index, block_bytes, big_bytes.
// A word moves on either channel at a clock edge where valid is high and stall low.
// in_stall is high from the cycle after a request is taken until its result is
// handed to the output register; the output register then holds the result while
// out_stall is high, and the next request is already taken and worked on.
// Path from acceptance to the output register, by kind of request:
//   zero size: decode, then emit; big request: decode, round (add and mask to a
//   page multiple), emit; small grant: decode, then a scan of the open pages from
//   the newest down, opening a new page if none matches, or straight to opening
//   one with no page open, then pick and emit; out of pages: the open step finds
//   the table full or no slot in a fresh page. While the output register still
//   holds the previous word, the result waits in the result register.
// header_bytes is written on the cfg channel (cfg_valid and cfg_ready, ready is
// always high); write it only between requests. Pages opened earlier keep the
// slot count they got.
// Reset (rst, synchronous) empties the page table, sets header_bytes to 32 and
// drops out_valid; entries past the open count are never read.
`default_nettype none

module size_class_bitmap_allocator #(
  parameter int SLOTS_MAX  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] header_bytes,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] request_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [3:0]       page_index,
  output logic [5:0]       slot_index,
  output logic [10:0]      block_bytes,
  output logic [32:0]      big_bytes
);

  import scba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  scba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  scba_dp #(
    .SLOTS_MAX  (SLOTS_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_header (header_bytes),
    .req_in     (request_bytes),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (status),
    .out_page   (page_index),
    .out_slot   (slot_index),
    .out_block  (block_bytes),
    .out_big    (big_bytes)
  );

  // A taken request closes the input until its result is out
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a request was taken");

  // Never overwrite a word the receiver has not taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output register loaded while occupied");

  // A page is opened only when there is room and it holds a slot
  a_open_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.open_page |-> (!stat.table_full && !stat.no_slots))
    else $error("page opened with table full or no slots");

  // Granted words carry a real size class
  a_grant_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_GRANT)) |-> (block_bytes >= 11'd64))
    else $error("granted slot without a size class");

endmodule

`default_nettype wire

// File: tb/size_class_bitmap_allocator_tb.sv
// Self-checking testbench for the size-class bitmap allocator: predicted allocations vs. DUT words.
`default_nettype none

module size_class_bitmap_allocator_tb;
  import scba_pkg::*;

  localparam int SLOTS_MAX   = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // One result word as seen on the output ports
  typedef struct packed {
    status_t             st;
    logic [PAGE_W-1:0]   pg;
    logic [SLOT_W-1:0]   sl;
    logic [BLK_W-1:0]    blk;
    logic [BIG_W-1:0]    big;
  } alloc_word_t;

  // Allocator predictor plus the queue of predicted result words
  class alloc_scoreboard;
    logic [HDR_W-1:0] hdr;
    bit               page_live[PAGES];
    logic [2:0]       page_cls[PAGES];
    logic [63:0]      page_map[PAGES];
    int               open_cnt;
    alloc_word_t      predicted_allocs[$];
    int               mismatches;
    int               status_cnt[4];

    function new();
      hdr = 12'd32;
      open_cnt = 0;
      mismatches = 0;
      foreach (page_live[i]) page_live[i] = 1'b0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
    endfunction

    function void set_header(logic [HDR_W-1:0] value);
      hdr = value;
    endfunction

    function int pending();
      return predicted_allocs.size();
    endfunction

    // Allocate against the page table copy and return the expected word
    function alloc_word_t predict_allocation(logic [REQ_W-1:0] req);
      alloc_word_t r;
      logic [BIG_W-1:0] rounded;
      int code;
      int e;
      int hit;
      int slots;
      int slot;
      r = '0;
      if (req == '0) begin
        r.st = ST_ZERO;
        return r;
      end
      if (req > SMALL_LIMIT) begin
        // round up to a page multiple; 33 bits hold the carry
        rounded = {1'b0, req} + BIG_W'(PAGE_BYTES - 1);
        r.st  = ST_BIG;
        r.big = {rounded[BIG_W-1:12], 12'd0};
        return r;
      end
      code = 0;
      while (code < MAX_CLASS && (64 << code) < req) code++;
      // newest page first
      hit = -1;
      for (e = open_cnt - 1; e >= 0; e--) begin
        if (page_live[e] && page_cls[e] == code[2:0] && page_map[e] != '1) begin
          hit = e;
          break;
        end
      end
      if (hit < 0) begin
        if (open_cnt >= PAGES) begin
          r.st = ST_FULL;
          return r;
        end
        slots = (PAGE_BYTES - int'(hdr)) >> (code + MIN_CLASS_LOG);
        if (slots > SLOTS_MAX) slots = SLOTS_MAX;
        // header leaves no room for even one slot
        if (slots == 0) begin
          r.st = ST_FULL;
          return r;
        end
        hit = open_cnt;
        page_live[hit] = 1'b1;
        page_cls[hit]  = code[2:0];
        page_map[hit]  = (slots >= 64) ? 64'd0 : ~((64'd1 << slots) - 64'd1);
        open_cnt++;
      end
      for (slot = 0; slot < 64; slot++) begin
        if (!page_map[hit][slot]) break;
      end
      page_map[hit][slot] = 1'b1;
      r.st  = ST_GRANT;
      r.pg  = hit[PAGE_W-1:0];
      r.sl  = slot[SLOT_W-1:0];
      r.blk = BLK_W'(64 << code);
      return r;
    endfunction

    function void note_request(logic [REQ_W-1:0] req);
      alloc_word_t w;
      w = predict_allocation(req);
      status_cnt[w.st]++;
      predicted_allocs.push_back(w);
    endfunction

    function void field_check(string name, logic [BIG_W-1:0] want, logic [BIG_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_result(alloc_word_t got);
      alloc_word_t want;
      if (predicted_allocs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result word with nothing predicted: status %0d", got.st);
        return;
      end
      want = predicted_allocs.pop_front();
      field_check("status", BIG_W'(want.st), BIG_W'(got.st));
      field_check("page_index", BIG_W'(want.pg), BIG_W'(got.pg));
      field_check("slot_index", BIG_W'(want.sl), BIG_W'(got.sl));
      field_check("block_bytes", BIG_W'(want.blk), BIG_W'(got.blk));
      field_check("big_bytes", want.big, got.big);
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [HDR_W-1:0]  header_bytes = 12'd32;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  request_bytes = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [3:0]        page_index;
  logic [5:0]        slot_index;
  logic [10:0]       block_bytes;
  logic [32:0]       big_bytes;

  alloc_scoreboard   sb;
  bit                idling_on = 1'b1;
  bit                hold_req = 1'b0;
  int                n_sent = 0;

  size_class_bitmap_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .header_bytes  (header_bytes),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .request_bytes (request_bytes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .page_index    (page_index),
    .slot_index    (slot_index),
    .block_bytes   (block_bytes),
    .big_bytes     (big_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: check accepted words, drive stall bursts and the long hold-off
  initial begin : drain
    alloc_word_t got;
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.st  = status;
        got.pg  = page_index;
        got.sl  = slot_index;
        got.blk = block_bytes;
        got.big = big_bytes;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request word; valid stays high after acceptance for back-to-back words
  task automatic send_request(input logic [REQ_W-1:0] req);
    int gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    request_bytes <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(req);
    n_sent++;
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain_all();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Idle block, new header, then a batch of random requests
  task automatic run_phase(input logic [HDR_W-1:0] hdr, input int count);
    int pick;
    int bound;
    logic [REQ_W-1:0] req;
    drain_all();
    cfg_valid    <= 1'b1;
    header_bytes <= hdr;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_header(hdr);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        req = '0;
      end else if (pick < 16) begin
        req = $urandom;
      end else if (pick < 26) begin
        req = $urandom_range(1025, 20000);
      end else if (pick < 60) begin
        // class boundaries: one below, at, one above
        bound = 64 << $urandom_range(0, 4);
        req = bound + $urandom_range(0, 2) - 1;
      end else begin
        req = $urandom_range(1, 1024);
      end
      send_request(req);
    end
  endtask

  // Main sequence
  initial begin : stimulus
    logic [REQ_W-1:0] directed[$];
    sb = new();
    directed = '{32'd0, 32'd1, 32'd63, 32'd64, 32'd65, 32'd128, 32'd129, 32'd256,
                 32'd257, 32'd512, 32'd513, 32'd1023, 32'd1024, 32'd1025, 32'd4096,
                 32'd4097, 32'h8000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'd64};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and each class edge at the reset header
    foreach (directed[i]) send_request(directed[i]);

    // Header sweep; near-page headers give pages with one slot or none
    run_phase(12'd4095, 40);
    run_phase(12'd4000, 60);
    run_phase(12'd0, 120);
    run_phase(12'd3072, 120);

    // Long output hold-off starting on an empty block while requests keep coming
    drain_all();
    hold_req = 1'b1;
    run_phase(12'd32, 200);
    run_phase(HDR_W'($urandom_range(0, 3072)), 400);
    run_phase(12'd2048, 400);

    // Last stretch without any idling
    drain_all();
    idling_on = 1'b0;
    run_phase(12'd1024, 600);

    drain_all();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests: %0d zero, %0d granted, %0d big, %0d out of pages",
             n_sent, sb.status_cnt[ST_ZERO], sb.status_cnt[ST_GRANT],
             sb.status_cnt[ST_BIG], sb.status_cnt[ST_FULL]);
    $display("%0d of %0d pages opened over 9 header settings, with a %0d-cycle output hold-off",
             sb.open_cnt, PAGES, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: size_class_bitmap_allocator.f
sv/scba_pkg.sv
sv/scba_ram.sv
sv/scba_ctrl.sv
sv/scba_dp.sv
sv/size_class_bitmap_allocator.sv
tb/size_class_bitmap_allocator_tb.sv
